FILE: src/dlf_pkg.sv
// Package for the dead-zone lag follow filter: shared widths, constants, codes,
// command structures, the angle wrap function and the smoothing table recurrence.
// No dependencies; every other file of the block refers to it by scoped names.
package dlf_pkg;

    // Field and register widths
    localparam int ANG_W      = 15;
    localparam int DT_W       = 16;
    localparam int SPEED_W    = 10;
    localparam int ZONE_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;

    // Angle format: units of 1/64 degree
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN       = 2 * HALF_TURN;
    // Working width for sums of an angle and a lag or a difference of two angles
    localparam int CALC_W          = 17;

    // Smoothing index: (speed * dt) / 500000 through a reciprocal multiply
    localparam int     PROD_W         = SPEED_W + DT_W;
    localparam int     EXP_STEP_UNITS = 500000;
    localparam int     RECIP_SHIFT    = 35;
    localparam longint RECIP_FULL     = (64'd1 << RECIP_SHIFT) / EXP_STEP_UNITS;
    localparam int     QUOT_W         = 9;
    localparam int     CORR_W         = 28;

    // Shared multiplier
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 19;
    localparam int MUL_W   = MUL_A_W + MUL_B_W;

    // Smoothing factor in Q0.16, one extra bit so that 1.0 fits
    localparam int FRAC_W   = 17;
    localparam int ONE_Q16  = 65536;
    localparam int STEP_LSB = 16;

    localparam logic [MUL_B_W-1:0] RECIP_MULT = MUL_B_W'(RECIP_FULL);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG      = 2'd2;

    // Configuration reset values
    localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd96;
    localparam logic [ZONE_W-1:0]  ZONE_RESET  = 14'd640;
    localparam logic [ZONE_W-1:0]  LAG_RESET   = 14'd1920;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_RECIP,
        ST_CORR,
        ST_LOOK,
        ST_YAW,
        ST_PITCH,
        ST_UPD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_CLAMP,
        MODE_MOVE
    } t_axis_mode;

    typedef struct packed {
        logic diff;
        logic classify;
        logic update;
    } t_axis_cmd;

    typedef struct packed {
        logic      capture;
        logic      prod;
        logic      recip;
        logic      corr;
        logic      look;
        logic      step_yaw;
        logic      step_pitch;
        t_axis_cmd yaw;
        t_axis_cmd pitch;
        logic      load_out;
    } t_dp_cmd;

    // Wraps into [-half turn, half turn); valid for inputs within one and a half turns.
    function automatic logic signed [CALC_W-1:0] wrap_angle(
        input logic signed [CALC_W-1:0] v
    );
        logic signed [CALC_W-1:0] half;
        logic signed [CALC_W-1:0] full;
        half = CALC_W'(HALF_TURN);
        full = CALC_W'(FULL_TURN);
        if (v >= half) begin
            return v - full;
        end else if (v < -half) begin
            return v + full;
        end else begin
            return v;
        end
    endfunction

    // One step of the exp(-1/32) recurrence in Q0.32, rounded.
    function automatic logic [63:0] exp_next(input logic [63:0] e);
        return (e * 64'd4162825044 + 64'h8000_0000) >> 32;
    endfunction

    // Table entry 1 - exp(-k/32) in Q0.16 from the current Q0.32 exponential.
    function automatic logic [FRAC_W-1:0] frac_entry(input logic [63:0] e);
        logic [63:0] v;
        v = 64'd65536 - ((e + 64'h8000) >> 16);
        return v[FRAC_W-1:0];
    endfunction

endpackage

FILE: src/dlf_axis.sv
// One axis of the follow filter: stored angle, wrapped difference, dead-zone and
// lag classification, and the final update. Depends on dlf_pkg.
module dlf_axis (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dlf_pkg::t_axis_cmd                  i_cmd,
    input  logic signed [dlf_pkg::ANG_W-1:0]    i_target,
    input  logic        [dlf_pkg::ZONE_W-1:0]   i_dead_zone,
    input  logic        [dlf_pkg::ZONE_W-1:0]   i_max_lag,
    input  logic        [dlf_pkg::ZONE_W-1:0]   i_step,
    output logic        [dlf_pkg::ZONE_W-1:0]   o_excess,
    output logic signed [dlf_pkg::ANG_W-1:0]    o_cur
);

    localparam int CW = dlf_pkg::CALC_W;
    localparam int AW = dlf_pkg::ANG_W;
    localparam int ZW = dlf_pkg::ZONE_W;

    logic signed [AW-1:0]  r_cur;
    logic signed [CW-1:0]  r_diff;
    dlf_pkg::t_axis_mode   r_mode;
    logic                  r_pos;
    logic        [ZW-1:0]  r_excess;
    logic signed [AW-1:0]  r_clamp;

    logic signed [CW-1:0]  cur_ext;
    logic signed [CW-1:0]  tgt_ext;
    logic signed [CW-1:0]  dz_ext;
    logic signed [CW-1:0]  lag_ext;
    logic signed [CW-1:0]  step_ext;
    logic signed [CW-1:0]  diff_wrap;
    logic signed [CW-1:0]  mag;
    logic                  pos;
    logic signed [CW-1:0]  clamp_wrap;
    logic signed [CW-1:0]  moved_wrap;
    logic signed [CW-1:0]  excess_full;
    dlf_pkg::t_axis_mode   mode;

    assign cur_ext  = $signed({{(CW-AW){r_cur[AW-1]}}, r_cur});
    assign tgt_ext  = $signed({{(CW-AW){i_target[AW-1]}}, i_target});
    assign dz_ext   = $signed({{(CW-ZW){1'b0}}, i_dead_zone});
    assign lag_ext  = $signed({{(CW-ZW){1'b0}}, i_max_lag});
    assign step_ext = $signed({{(CW-ZW){1'b0}}, i_step});

    assign diff_wrap   = dlf_pkg::wrap_angle(tgt_ext - cur_ext);
    assign mag         = r_diff[CW-1] ? -r_diff : r_diff;
    assign pos         = !r_diff[CW-1] && (r_diff != '0);
    assign excess_full = mag - dz_ext;
    assign clamp_wrap  = dlf_pkg::wrap_angle(pos ? tgt_ext - lag_ext : tgt_ext + lag_ext);
    assign moved_wrap  = dlf_pkg::wrap_angle(r_pos ? cur_ext + step_ext : cur_ext - step_ext);

    // The dead-zone test wins over the lag test.
    always_comb begin
        if (mag <= dz_ext) begin
            mode = dlf_pkg::MODE_HOLD;
        end else if (mag > lag_ext) begin
            mode = dlf_pkg::MODE_CLAMP;
        end else begin
            mode = dlf_pkg::MODE_MOVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (i_cmd.update) begin
            case (r_mode)
                dlf_pkg::MODE_HOLD:  r_cur <= r_cur;
                dlf_pkg::MODE_CLAMP: r_cur <= r_clamp;
                dlf_pkg::MODE_MOVE:  r_cur <= moved_wrap[AW-1:0];
                default:             r_cur <= r_cur;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_diff <= diff_wrap;
        end
        if (i_cmd.classify) begin
            r_mode   <= mode;
            r_pos    <= pos;
            r_excess <= excess_full[ZW-1:0];
            r_clamp  <= clamp_wrap[AW-1:0];
        end
    end

    assign o_excess = r_excess;
    assign o_cur    = r_cur;

endmodule

FILE: src/dlf_ctrl.sv
// Sequencing controller of the follow filter: state register, command decode and
// the output word valid flag. Depends on dlf_pkg.
module dlf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_m_ready,
    output logic             o_s_ready,
    output logic             o_m_valid,
    output dlf_pkg::t_dp_cmd o_cmd
);

    dlf_pkg::t_state r_state;
    dlf_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_ready;
        o_cmd       = '0;
        o_s_ready   = 1'b0;
        case (r_state)
            dlf_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = dlf_pkg::ST_PROD;
                end
            end
            dlf_pkg::ST_PROD: begin
                o_cmd.prod       = 1'b1;
                o_cmd.yaw.diff   = 1'b1;
                o_cmd.pitch.diff = 1'b1;
                n_state          = dlf_pkg::ST_RECIP;
            end
            dlf_pkg::ST_RECIP: begin
                o_cmd.recip          = 1'b1;
                o_cmd.yaw.classify   = 1'b1;
                o_cmd.pitch.classify = 1'b1;
                n_state              = dlf_pkg::ST_CORR;
            end
            dlf_pkg::ST_CORR: begin
                o_cmd.corr = 1'b1;
                n_state    = dlf_pkg::ST_LOOK;
            end
            dlf_pkg::ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = dlf_pkg::ST_YAW;
            end
            dlf_pkg::ST_YAW: begin
                o_cmd.step_yaw = 1'b1;
                n_state        = dlf_pkg::ST_PITCH;
            end
            dlf_pkg::ST_PITCH: begin
                o_cmd.step_pitch = 1'b1;
                o_cmd.yaw.update = 1'b1;
                n_state          = dlf_pkg::ST_UPD;
            end
            dlf_pkg::ST_UPD: begin
                o_cmd.pitch.update = 1'b1;
                n_state            = dlf_pkg::ST_OUT;
            end
            dlf_pkg::ST_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = dlf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dlf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_out_valid;

endmodule

FILE: src/dlf_datapath.sv
// Datapath of the follow filter: configuration registers, input and output words,
// shared multiplier, smoothing index and table, two axis units. Depends on
// dlf_pkg and dlf_axis.
module dlf_datapath #(
    parameter int DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dlf_pkg::t_dp_cmd                   i_cmd,
    input  logic [dlf_pkg::S_TDATA_W-1:0]      i_s_data,
    output logic [dlf_pkg::M_TDATA_W-1:0]      o_m_data,
    input  logic                               i_cfg_valid,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dlf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW    = dlf_pkg::ANG_W;
    localparam int CW    = dlf_pkg::CALC_W;
    localparam int ZW    = dlf_pkg::ZONE_W;
    localparam int SW    = dlf_pkg::SPEED_W;
    localparam int DW    = dlf_pkg::DT_W;
    localparam int FW    = dlf_pkg::FRAC_W;
    localparam int QW    = dlf_pkg::QUOT_W;
    localparam int PW    = dlf_pkg::PROD_W;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (IDX_W > QW) ? IDX_W : QW;

    typedef logic [FW-1:0] t_frac_rom [DEPTH];

    function automatic t_frac_rom build_rom();
        t_frac_rom   rom;
        logic [63:0] e;
        e = 64'd1 << 32;
        for (int k = 0; k < DEPTH; k++) begin
            rom[k] = dlf_pkg::frac_entry(e);
            e      = dlf_pkg::exp_next(e);
        end
        return rom;
    endfunction

    localparam t_frac_rom FRAC_ROM = build_rom();

    logic [SW-1:0]                r_speed;
    logic [ZW-1:0]                r_dz;
    logic [ZW-1:0]                r_lag;
    logic signed [AW-1:0]         r_ty;
    logic signed [AW-1:0]         r_tp;
    logic [DW-1:0]                r_dt;
    logic [dlf_pkg::MUL_W-1:0]    r_mul;
    logic [PW-1:0]                r_prod;
    logic [QW-1:0]                r_q0;
    logic [FW-1:0]                r_t;
    logic [AW-1:0]                r_out_yaw;
    logic [AW-1:0]                r_out_pitch;

    logic [dlf_pkg::MUL_A_W-1:0]  mul_a;
    logic [dlf_pkg::MUL_B_W-1:0]  mul_b;
    logic                         mul_en;
    logic [dlf_pkg::MUL_W-1:0]    mul_p;
    logic [QW-1:0]                q0_now;
    logic [QW-1:0]                quot;
    logic [CMP_W-1:0]             quot_ext;
    logic [IDX_W-1:0]             idx;
    logic signed [CW-1:0]         ty_in;
    logic signed [CW-1:0]         tp_in;
    logic signed [CW-1:0]         ty_wrap;
    logic signed [CW-1:0]         tp_wrap;
    logic [ZW-1:0]                yaw_excess;
    logic [ZW-1:0]                pitch_excess;
    logic [ZW-1:0]                step;
    logic signed [AW-1:0]         yaw_cur;
    logic signed [AW-1:0]         pitch_cur;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= dlf_pkg::SPEED_RESET;
            r_dz    <= dlf_pkg::ZONE_RESET;
            r_lag   <= dlf_pkg::LAG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dlf_pkg::CFG_FOLLOW_SPEED: r_speed <= i_cfg_data[SW-1:0];
                dlf_pkg::CFG_DEAD_ZONE:    r_dz    <= i_cfg_data[ZW-1:0];
                dlf_pkg::CFG_MAX_LAG:      r_lag   <= i_cfg_data[ZW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Targets are wrapped on capture so that the axis units see in-range angles.
    assign ty_in   = $signed({{(CW-AW){i_s_data[AW-1]}}, i_s_data[AW-1:0]});
    assign tp_in   = $signed({{(CW-AW){i_s_data[2*AW-1]}}, i_s_data[2*AW-1:AW]});
    assign ty_wrap = dlf_pkg::wrap_angle(ty_in);
    assign tp_wrap = dlf_pkg::wrap_angle(tp_in);

    assign q0_now = r_mul[dlf_pkg::RECIP_SHIFT +: QW];

    // One multiplier shared by the index division and both axis steps.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        if (i_cmd.prod) begin
            mul_a  = dlf_pkg::MUL_A_W'(r_speed);
            mul_b  = dlf_pkg::MUL_B_W'(r_dt);
            mul_en = 1'b1;
        end else if (i_cmd.recip) begin
            mul_a  = dlf_pkg::MUL_A_W'(r_mul[PW-1:0]);
            mul_b  = dlf_pkg::RECIP_MULT;
            mul_en = 1'b1;
        end else if (i_cmd.corr) begin
            mul_a  = dlf_pkg::MUL_A_W'(q0_now + QW'(1));
            mul_b  = dlf_pkg::MUL_B_W'(dlf_pkg::EXP_STEP_UNITS);
            mul_en = 1'b1;
        end else if (i_cmd.step_yaw) begin
            mul_a  = dlf_pkg::MUL_A_W'(yaw_excess);
            mul_b  = dlf_pkg::MUL_B_W'(r_t);
            mul_en = 1'b1;
        end else if (i_cmd.step_pitch) begin
            mul_a  = dlf_pkg::MUL_A_W'(pitch_excess);
            mul_b  = dlf_pkg::MUL_B_W'(r_t);
            mul_en = 1'b1;
        end
    end

    assign mul_p = dlf_pkg::MUL_W'(mul_a) * dlf_pkg::MUL_W'(mul_b);

    // The reciprocal estimate is at most one short; one compare puts it right.
    assign quot     = r_q0 + QW'({2'b00, r_prod} >= r_mul[dlf_pkg::CORR_W-1:0]);
    assign quot_ext = CMP_W'(quot);
    assign idx      = (quot_ext > CMP_W'(DEPTH - 1)) ? IDX_W'(DEPTH - 1)
                                                     : quot_ext[IDX_W-1:0];

    assign step = r_mul[dlf_pkg::STEP_LSB +: ZW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ty <= ty_wrap[AW-1:0];
            r_tp <= tp_wrap[AW-1:0];
            r_dt <= i_s_data[2*AW +: DW];
        end
        if (mul_en) begin
            r_mul <= mul_p;
        end
        if (i_cmd.recip) begin
            r_prod <= r_mul[PW-1:0];
        end
        if (i_cmd.corr) begin
            r_q0 <= q0_now;
        end
        if (i_cmd.look) begin
            r_t <= (r_speed == '0) ? FW'(dlf_pkg::ONE_Q16) : FRAC_ROM[idx];
        end
        if (i_cmd.load_out) begin
            r_out_yaw   <= yaw_cur;
            r_out_pitch <= pitch_cur;
        end
    end

    dlf_axis u_yaw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd.yaw),
        .i_target    (r_ty),
        .i_dead_zone (r_dz),
        .i_max_lag   (r_lag),
        .i_step      (step),
        .o_excess    (yaw_excess),
        .o_cur       (yaw_cur)
    );

    dlf_axis u_pitch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd.pitch),
        .i_target    (r_tp),
        .i_dead_zone (r_dz),
        .i_max_lag   (r_lag),
        .i_step      (step),
        .o_excess    (pitch_excess),
        .o_cur       (pitch_cur)
    );

    assign o_m_data = {{(dlf_pkg::M_TDATA_W - 2*AW){1'b0}}, r_out_pitch, r_out_yaw};

endmodule

FILE: src/deadzone_lag_follow_filter.sv
// Top level of the dead-zone lag follow filter: controller plus datapath.
// Depends on dlf_pkg, dlf_ctrl, dlf_datapath (and through it dlf_axis).
//
// Each input word carries a target yaw, a target pitch (both in 1/64 degree,
// two's complement) and the frame time in microseconds; each produces exactly one
// output word with the lagging yaw and pitch after that tick. Per axis the wrapped
// difference to the target is taken: inside the dead zone the angle holds, beyond
// the maximum lag it is clamped to the target less (or plus) that lag, otherwise
// it moves by the excess over the dead zone times t = 1 - exp(-speed * dt),
// truncated towards zero, and is wrapped into [-180, 180) degrees. The factor t
// comes from a constant table indexed by speed * dt / 500000, saturated at the
// last entry; a speed of zero gives t = 1. The result is loaded into the output
// register once its word has been worked through, and no new word is taken before
// that: a single multiplier is used five times in turn
// (speed times frame time, the reciprocal multiply and its correction for the
// index, then the yaw and pitch steps), with the table read and the angle updates
// in between. The input is accepted only while the block is idle; a finished
// result waits in its own register, so a new word may be taken while the previous
// result is still pending. Configuration writes are always accepted and are
// intended only while the block is idle.
module deadzone_lag_follow_filter #(
    parameter int FRACTION_TABLE_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input words
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [14:0] target_yaw, [29:15] target_pitch, [45:30] frame_time, [47:46] zero
    input  logic [dlf_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // Output words
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [14:0] panel_yaw, [29:15] panel_pitch, [31:30] zero
    output logic [dlf_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // Configuration writes: 0 follow_speed, 1 dead_zone, 2 max_lag
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dlf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    dlf_pkg::t_dp_cmd cmd;

    // Registers are plain flops, so a write can always be taken.
    assign o_cfg_ready = 1'b1;

    dlf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_m_ready (i_m_tready),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .o_cmd     (cmd)
    );

    dlf_datapath #(
        .DEPTH (FRACTION_TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_s_data    (i_s_tdata),
        .o_m_data    (o_m_tdata),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

FILE: src/dlf_checker.sv
// Port-level checker for the follow filter and its bind to the top level.
// Depends on dlf_pkg and deadzone_lag_follow_filter.
module dlf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [dlf_pkg::M_TDATA_W-1:0]      o_m_tdata
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // One word at a time: after acceptance the input stays closed while it is worked.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while the previous word is in work");

    a_busy_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> ##7 !o_s_tready)
        else $error("input reopened before the result was produced");

    // Both output angles lie in the wrapped range and the padding is clear.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ($signed(o_m_tdata[14:0]) >= -dlf_pkg::HALF_TURN) &&
            ($signed(o_m_tdata[14:0]) < dlf_pkg::HALF_TURN) &&
            ($signed(o_m_tdata[29:15]) >= -dlf_pkg::HALF_TURN) &&
            ($signed(o_m_tdata[29:15]) < dlf_pkg::HALF_TURN) &&
            (o_m_tdata[31:30] == 2'b00))
        else $error("output angle outside the wrapped range");

endmodule

bind deadzone_lag_follow_filter dlf_checker u_dlf_checker (.*);
